// ===== design/array_list_engine_top_defines.svh =====
// Assertion macros for the array list engine.
`ifndef ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ALE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ale_pkg.sv =====
`default_nettype none

package ale_pkg;

    // Store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;

    // Width used to compare a position against the entry count
    localparam int CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((INDEX_W + COUNT_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd5;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } ale_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
    } ale_res_t;

endpackage

`default_nettype wire

// ===== design/array_list_engine_top.sv =====
// Accept to m_tvalid: push back, pop back, op 7 and rejected requests go
// straight to the result; the others first walk the store at one word per
// cycle: count - position words for insert, one less for erase, count for
// push front, up to count for find, count - 1 for pop front.
// Throughput: one request at a time; the next is taken in the cycle after a result leaves the core.
// Reset: asynchronous, active low; empties the list (store contents stay).
`default_nettype none

`include "array_list_engine_top_defines.svh"

module array_list_engine_top
    import ale_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], position[41:32]
    input  wire logic [OP_W-1:0]      s_tuser,   // op[2:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // index[9:0], count[20:10]
    output logic [STATUS_W-1:0]       m_tuser    // status[2:0]
);

    ale_req_t req;
    ale_res_t res;
    logic     res_valid;
    logic     res_ready;

    logic     out_valid_reg, out_valid_next;
    ale_res_t out_reg, out_next;

    // Unpack the request
    assign req.op       = s_tuser;
    assign req.value    = s_tdata[DATA_W-1:0];
    assign req.position = s_tdata[DATA_W+POS_W-1:DATA_W];

    ale_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output stage: load when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = M_TDATA_W'({out_reg.count, out_reg.index});

    // Checks
    `ALE_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready after accept")
    `ALE_ASSERT_SAME(a_full_count, m_tvalid && (m_tuser == ST_FULL), m_tdata[INDEX_W+COUNT_W-1:INDEX_W] == COUNT_W'(DEPTH), "full status with count below depth")
    `ALE_ASSERT_SAME(a_miss_index, m_tvalid && (m_tuser == ST_NOTFOUND || m_tuser == ST_EMPTY), m_tdata[INDEX_W-1:0] == '0, "nonzero index without a match")

endmodule

`default_nettype wire

// ===== design/ale_ram.sv =====
`default_nettype none

module ale_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ale_core.sv =====
`default_nettype none

module ale_core
    import ale_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire ale_req_t req,
    output logic          req_ready,
    output logic          res_valid,
    output ale_res_t      res,
    input  wire logic     res_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [1:0] M_UP   = 2'd0;
    localparam logic [1:0] M_DOWN = 2'd1;
    localparam logic [1:0] M_FIND = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [1:0]                mode_reg, mode_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [ADDR_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic                      rdv_reg, rdv_next;
    logic [ADDR_W-1:0]         rda_reg, rda_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [ADDR_W-1:0]         index_reg, index_next;
    logic                      found_reg, found_next;

    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [DATA_W-1:0]         wdata;
    logic                      re;
    logic [DATA_W-1:0]         rd_data;

    logic                      full;
    logic                      empty;
    logic                      pos_bad;
    logic                      hit;

    ale_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (ptr_reg),
        .rdata (rd_data)
    );

    // Decode list condition for the incoming request
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pos_bad = (CMP_W'(req.position) >= CMP_W'(cnt_reg));
    assign hit     = (state_reg == S_RUN) && (mode_reg == M_FIND) && rdv_reg
                     && !found_reg && (rd_data == val_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res.status = status_reg;
    assign res.index  = INDEX_W'(index_reg);
    assign res.count  = COUNT_W'(cnt_reg);

    // Sequence one request: decode, walk the store when the op needs it, report
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        rdv_next    = 1'b0;
        rda_next    = rda_reg;
        status_next = status_reg;
        index_next  = index_reg;
        found_next  = found_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next  = S_FIN;
                    status_next = ST_OK;
                    index_next  = '0;
                    found_next  = 1'b0;
                    val_next    = req.value;
                    case (req.op)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mode_next  = M_UP;
                                pos_next   = '0;
                                rem_next   = cnt_reg;
                                ptr_next   = ADDR_W'(cnt_reg - 1'b1);
                                state_next = S_RUN;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                mode_next  = M_UP;
                                pos_next   = ADDR_W'(req.position);
                                rem_next   = cnt_reg - CNT_W'(req.position);
                                ptr_next   = ADDR_W'(cnt_reg - 1'b1);
                                state_next = S_RUN;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mode_next  = M_DOWN;
                                pos_next   = '0;
                                rem_next   = cnt_reg - 1'b1;
                                ptr_next   = ADDR_W'(1);
                                state_next = S_RUN;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (pos_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                mode_next  = M_DOWN;
                                pos_next   = ADDR_W'(req.position);
                                rem_next   = cnt_reg - 1'b1 - CNT_W'(req.position);
                                ptr_next   = ADDR_W'(req.position) + 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = cnt_reg[ADDR_W-1:0];
                                wdata    = req.value;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        OP_FIND:
                        begin
                            status_next = ST_NOTFOUND;
                            mode_next   = M_FIND;
                            rem_next    = cnt_reg;
                            ptr_next    = '0;
                            state_next  = S_RUN;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // Retire the word read last cycle: move it or compare it
                if (rdv_reg)
                begin
                    case (mode_reg)
                        M_UP:
                        begin
                            we    = 1'b1;
                            waddr = rda_reg + 1'b1;
                            wdata = rd_data;
                        end
                        M_DOWN:
                        begin
                            we    = 1'b1;
                            waddr = rda_reg - 1'b1;
                            wdata = rd_data;
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                found_next  = 1'b1;
                                status_next = ST_OK;
                                index_next  = rda_reg;
                                rem_next    = '0;
                            end
                        end
                    endcase
                end

                // Issue the next read, upward or downward
                if ((rem_reg != '0) && !hit && !found_reg)
                begin
                    re       = 1'b1;
                    rdv_next = 1'b1;
                    rda_next = ptr_reg;
                    rem_next = rem_reg - 1'b1;
                    ptr_next = (mode_reg == M_UP) ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                end

                // Finish once the walk has drained
                if (((rem_reg == '0) || found_reg) && !rdv_reg)
                begin
                    state_next = S_FIN;
                    case (mode_reg)
                        M_UP:
                        begin
                            we       = 1'b1;
                            waddr    = pos_reg;
                            wdata    = val_reg;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        M_DOWN:
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rdv_reg   <= rdv_next;
            found_reg <= found_next;
            rem_reg   <= rem_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        rda_reg    <= rda_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

endmodule

`default_nettype wire
